>>> hdl/rdi_pkg.sv
// Shared types, codes and default sizes for the region dwell / intrusion rule.
// Used by every module under hdl.
package rdi_pkg;

    localparam int MAX_TRACKS_DEF   = 64;
    localparam int MAX_VERTICES_DEF = 16;
    localparam int COORD_BITS_DEF   = 16;
    localparam int MIN_POLY_VERTICES = 3;
    localparam int Q_DEPTH          = 2;
    localparam int CFG_IDX_W        = 2;

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_OBS   = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [1:0] KIND_NONE     = 2'd0;
    localparam logic [1:0] KIND_ENTERED  = 2'd1;
    localparam logic [1:0] KIND_LEFT     = 2'd2;
    localparam logic [1:0] KIND_INTRUDED = 2'd3;

    localparam logic [1:0] MODE_ENTER   = 2'd0;
    localparam logic [1:0] MODE_LEAVE   = 2'd1;
    localparam logic [1:0] MODE_INTRUDE = 2'd2;
    localparam logic [1:0] MODE_SILENT  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_RULE_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DWELL_TIME   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 2'd2;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_OBS   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef struct packed {
        op_t         op;
        logic        vtx_ok;
        logic [3:0]  vertex_index;
        logic [15:0] coord_x;
        logic [15:0] coord_y;
        logic [31:0] track_id;
        logic [63:0] timestamp_ns;
        logic [7:0]  object_class;
        logic [15:0] box_left;
        logic [15:0] box_top;
        logic [15:0] box_width;
        logic [15:0] box_height;
    } item_t;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [31:0] event_track;
        logic [63:0] event_time;
        logic [7:0]  event_class;
        logic [15:0] event_box_left;
        logic [15:0] event_box_top;
        logic [15:0] event_box_width;
        logic [15:0] event_box_height;
        logic        inside_now;
        logic        table_full;
    } res_t;

endpackage

>>> hdl/rdi_channels.sv
// Valid/ready channel interfaces for observation words and event words.
// Field widths follow the fixed formats of the rule block.
interface rdi_item_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [3:0]         vertex_index;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic [31:0]        track_id;
    logic [63:0]        timestamp_ns;
    logic [7:0]         object_class;
    logic signed [15:0] box_left;
    logic signed [15:0] box_top;
    logic [15:0]        box_width;
    logic [15:0]        box_height;

    modport source (output valid, action, vertex_index, coord_x, coord_y, track_id,
                    timestamp_ns, object_class, box_left, box_top, box_width,
                    box_height, input ready);
    modport sink (input valid, action, vertex_index, coord_x, coord_y, track_id,
                  timestamp_ns, object_class, box_left, box_top, box_width,
                  box_height, output ready);
endinterface

interface rdi_result_if;
    logic               valid;
    logic               ready;
    logic [1:0]         event_kind;
    logic [31:0]        event_track;
    logic [63:0]        event_time;
    logic [7:0]         event_class;
    logic signed [15:0] event_box_left;
    logic signed [15:0] event_box_top;
    logic [15:0]        event_box_width;
    logic [15:0]        event_box_height;
    logic               inside_now;
    logic               table_full;

    modport source (output valid, event_kind, event_track, event_time, event_class,
                    event_box_left, event_box_top, event_box_width, event_box_height,
                    inside_now, table_full, input ready);
    modport sink (input valid, event_kind, event_track, event_time, event_class,
                  event_box_left, event_box_top, event_box_width, event_box_height,
                  inside_now, table_full, output ready);
endinterface

>>> hdl/rdi_front.sv
// Input stage: registers each incoming word and classifies its action.
// Depends on rdi_pkg and rdi_item_if.
module rdi_front #(
    parameter int MAX_VERTICES = rdi_pkg::MAX_VERTICES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    rdi_item_if.sink       item,
    output logic           push_valid,
    input  logic           push_ready,
    output rdi_pkg::item_t push_item
);

    logic           fv_reg;
    rdi_pkg::item_t fitem_reg;
    rdi_pkg::item_t dec;

    assign item.ready = !fv_reg || push_ready;
    assign push_valid = fv_reg;
    assign push_item  = fitem_reg;

    always_comb
    begin
        dec              = '0;
        case (item.action)
            rdi_pkg::ACT_LOAD:  dec.op = rdi_pkg::OP_LOAD;
            rdi_pkg::ACT_OBS:   dec.op = rdi_pkg::OP_OBS;
            rdi_pkg::ACT_CLEAR: dec.op = rdi_pkg::OP_CLEAR;
            default:            dec.op = rdi_pkg::OP_NOP;
        endcase
        dec.vtx_ok       = (32'(item.vertex_index) < MAX_VERTICES);
        dec.vertex_index = item.vertex_index;
        dec.coord_x      = item.coord_x;
        dec.coord_y      = item.coord_y;
        dec.track_id     = item.track_id;
        dec.timestamp_ns = item.timestamp_ns;
        dec.object_class = item.object_class;
        dec.box_left     = item.box_left;
        dec.box_top      = item.box_top;
        dec.box_width    = item.box_width;
        dec.box_height   = item.box_height;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg    <= 1'b0;
            fitem_reg <= '0;
        end
        else if (item.ready)
        begin
            fv_reg <= item.valid;
            if (item.valid)
            begin
                fitem_reg <= dec;
            end
        end
    end

endmodule

>>> hdl/rdi_queue.sv
// Short queue of classified words between the input stage and the rule engine.
// Depends on rdi_pkg.
module rdi_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  rdi_pkg::item_t push_item,
    output logic           pop_valid,
    input  logic           pop_ready,
    output rdi_pkg::item_t pop_item
);

    localparam int PW = (rdi_pkg::Q_DEPTH > 1) ? $clog2(rdi_pkg::Q_DEPTH) : 1;
    localparam int CW = $clog2(rdi_pkg::Q_DEPTH + 1);

    rdi_pkg::item_t mem_reg [rdi_pkg::Q_DEPTH];
    logic [PW-1:0]  wr_reg;
    logic [PW-1:0]  rd_reg;
    logic [CW-1:0]  cnt_reg;
    logic           do_push;
    logic           do_pop;

    assign push_ready = (cnt_reg != CW'(rdi_pkg::Q_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_item   = mem_reg[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= (32'(wr_reg) == rdi_pkg::Q_DEPTH - 1) ? '0 : wr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_reg <= (32'(rd_reg) == rdi_pkg::Q_DEPTH - 1) ? '0 : rd_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

>>> hdl/rdi_back.sv
// Rule engine: polygon store, edge pipeline, track table sweep and event output.
// Depends on rdi_pkg; holds the configuration registers.
module rdi_back #(
    parameter int MAX_TRACKS   = rdi_pkg::MAX_TRACKS_DEF,
    parameter int MAX_VERTICES = rdi_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = rdi_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [rdi_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                   cfg_data,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  rdi_pkg::item_t                q_item,
    output logic                          res_valid,
    input  logic                          res_ready,
    output rdi_pkg::res_t                 res
);

    localparam int CB  = COORD_BITS;
    localparam int VW  = $clog2(MAX_VERTICES);
    localparam int VCW = VW + 1;
    localparam int TW  = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int TCW = TW + 1;
    localparam int PW  = 2 * CB + 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_FETCH,
        ST_EVAL,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic        in_poly;
        logic        trig;
        logic [63:0] entered;
    } rec_t;

    function automatic logic signed [CB-1:0] to_coord(input logic [15:0] raw);
        logic [CB+15:0] ext;
        begin
            ext = {{CB{1'b0}}, raw};
            return ext[CB-1:0];
        end
    endfunction

    state_t state_reg;
    logic [1:0]  mode_reg;
    logic [63:0] dwell_reg;
    logic [4:0]  vcnt_reg;

    rdi_pkg::item_t cur_reg;
    logic signed [CB-1:0] px_reg;
    logic signed [CB-1:0] py_reg;

    logic signed [CB-1:0] vx_mem [MAX_VERTICES];
    logic signed [CB-1:0] vy_mem [MAX_VERTICES];
    logic signed [CB-1:0] vx_q;
    logic signed [CB-1:0] vy_q;
    logic [31:0] tag_mem [MAX_TRACKS];
    logic [31:0] tag_q;
    rec_t        rec_mem [MAX_TRACKS];
    rec_t        rec_q;

    logic [VCW-1:0] n_reg;
    logic [VCW-1:0] pcnt_reg;
    logic           pact_reg;
    logic           s1_valid_reg;
    logic           s1_first_reg;
    logic           s1_last_reg;
    logic signed [CB-1:0] lx_reg;
    logic signed [CB-1:0] ly_reg;
    logic           s2_valid_reg;
    logic           s2_last_reg;
    logic signed [PW-1:0] p1_reg;
    logic signed [PW-1:0] p2_reg;
    logic signed [PW-1:0] p3_reg;
    logic signed [PW-1:0] p4_reg;
    logic           bbox_reg;
    logic           cross_reg;
    logic           dypos_reg;
    logic           dyneg_reg;
    logic           par_reg;
    logic           bnd_reg;
    logic           pdone_reg;

    logic [TCW-1:0] tcnt_reg;
    logic           t1_valid_reg;
    logic [TW-1:0]  t1_idx_reg;
    logic           t1_last_reg;
    logic           found_reg;
    logic [TW-1:0]  slot_reg;
    logic           free_found_reg;
    logic [TW-1:0]  free_slot_reg;
    logic           tdone_reg;
    logic [MAX_TRACKS-1:0] valid_reg;

    rdi_pkg::res_t pend_reg;
    rdi_pkg::res_t out_reg;
    logic          out_valid_reg;

    logic                 start;
    logic [31:0]          n32;
    logic [VCW-1:0]       n_next;
    logic                 vtx_we;
    logic [VW-1:0]        vtx_waddr;
    logic [VCW-1:0]       pm1;
    logic [VW-1:0]        vtx_raddr;
    logic signed [CB:0]   cxe, cye, lxe, lye, pxe, pye;
    logic signed [CB:0]   da, db, dc, dd, de, df, dy;
    logic signed [PW-1:0] p1_next, p2_next, p3_next, p4_next;
    logic                 bbox_next;
    logic                 run_done;
    logic                 inside_w;
    logic                 new_we;
    logic                 rec_we;
    logic [TW-1:0]        rec_waddr;
    rec_t                 rec_wdata;
    rec_t                 ev;
    logic [1:0]           ev_kind;
    logic                 out_free;

    assign q_ready   = (state_reg == ST_IDLE);
    assign start     = q_ready && q_valid;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;
    assign out_free  = !out_valid_reg || res_ready;

    assign n32    = (32'(vcnt_reg) > MAX_VERTICES) ? MAX_VERTICES : 32'(vcnt_reg);
    assign n_next = VCW'(n32);

    assign vtx_we    = start && (q_item.op == rdi_pkg::OP_LOAD) && q_item.vtx_ok;
    assign vtx_waddr = VW'(q_item.vertex_index);
    assign pm1       = (pcnt_reg == '0) ? n_reg - 1'b1 : pcnt_reg - 1'b1;
    assign vtx_raddr = pm1[VW-1:0];

    always_ff @(posedge clk)
    begin
        if (vtx_we)
        begin
            vx_mem[vtx_waddr] <= to_coord(q_item.coord_x);
            vy_mem[vtx_waddr] <= to_coord(q_item.coord_y);
        end
        vx_q <= vx_mem[vtx_raddr];
        vy_q <= vy_mem[vtx_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (new_we)
        begin
            tag_mem[free_slot_reg] <= cur_reg.track_id;
        end
        tag_q <= tag_mem[tcnt_reg[TW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (rec_we)
        begin
            rec_mem[rec_waddr] <= rec_wdata;
        end
        rec_q <= rec_mem[slot_reg];
    end

    always_comb
    begin
        cxe = (CB+1)'(vx_q);
        cye = (CB+1)'(vy_q);
        lxe = (CB+1)'(lx_reg);
        lye = (CB+1)'(ly_reg);
        pxe = (CB+1)'(px_reg);
        pye = (CB+1)'(py_reg);
        da  = cxe - lxe;
        db  = pye - lye;
        dc  = cye - lye;
        dd  = pxe - lxe;
        de  = lxe - cxe;
        df  = pye - cye;
        dy  = lye - cye;
        p1_next = PW'(da) * PW'(db);
        p2_next = PW'(dc) * PW'(dd);
        p3_next = PW'(de) * PW'(df);
        p4_next = PW'(pxe - cxe) * PW'(dy);
        bbox_next = (px_reg >= ((lx_reg < vx_q) ? lx_reg : vx_q))
                 && (px_reg <= ((lx_reg > vx_q) ? lx_reg : vx_q))
                 && (py_reg >= ((ly_reg < vy_q) ? ly_reg : vy_q))
                 && (py_reg <= ((ly_reg > vy_q) ? ly_reg : vy_q));
    end

    assign run_done = (state_reg == ST_RUN) && pdone_reg && tdone_reg;
    assign inside_w = bnd_reg || par_reg;
    assign new_we   = run_done && !found_reg && free_found_reg;

    always_comb
    begin
        ev      = rec_q;
        ev_kind = rdi_pkg::KIND_NONE;
        if (!rec_q.in_poly && pend_reg.inside_now)
        begin
            ev.entered = cur_reg.timestamp_ns;
            ev.trig    = 1'b0;
            if (mode_reg == rdi_pkg::MODE_ENTER)
            begin
                ev_kind = rdi_pkg::KIND_ENTERED;
            end
        end
        else if (rec_q.in_poly && !pend_reg.inside_now)
        begin
            if (mode_reg == rdi_pkg::MODE_LEAVE)
            begin
                ev_kind = rdi_pkg::KIND_LEFT;
            end
            ev.entered = '0;
            ev.trig    = 1'b0;
        end
        if (pend_reg.inside_now && (mode_reg == rdi_pkg::MODE_INTRUDE) && !ev.trig
            && (ev.entered != '0) && (cur_reg.timestamp_ns >= ev.entered)
            && ((cur_reg.timestamp_ns - ev.entered) >= dwell_reg))
        begin
            ev_kind = rdi_pkg::KIND_INTRUDED;
            ev.trig = 1'b1;
        end
        ev.in_poly = pend_reg.inside_now;
    end

    always_comb
    begin
        rec_we    = 1'b0;
        rec_waddr = slot_reg;
        rec_wdata = ev;
        if (new_we)
        begin
            rec_we            = 1'b1;
            rec_waddr         = free_slot_reg;
            rec_wdata.in_poly = inside_w;
            rec_wdata.trig    = 1'b0;
            rec_wdata.entered = inside_w ? cur_reg.timestamp_ns : '0;
        end
        else if (state_reg == ST_EVAL)
        begin
            rec_we = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            mode_reg       <= '0;
            dwell_reg      <= '0;
            vcnt_reg       <= '0;
            cur_reg        <= '0;
            px_reg         <= '0;
            py_reg         <= '0;
            n_reg          <= '0;
            pcnt_reg       <= '0;
            pact_reg       <= 1'b0;
            s1_valid_reg   <= 1'b0;
            s1_first_reg   <= 1'b0;
            s1_last_reg    <= 1'b0;
            lx_reg         <= '0;
            ly_reg         <= '0;
            s2_valid_reg   <= 1'b0;
            s2_last_reg    <= 1'b0;
            p1_reg         <= '0;
            p2_reg         <= '0;
            p3_reg         <= '0;
            p4_reg         <= '0;
            bbox_reg       <= 1'b0;
            cross_reg      <= 1'b0;
            dypos_reg      <= 1'b0;
            dyneg_reg      <= 1'b0;
            par_reg        <= 1'b0;
            bnd_reg        <= 1'b0;
            pdone_reg      <= 1'b0;
            tcnt_reg       <= '0;
            t1_valid_reg   <= 1'b0;
            t1_idx_reg     <= '0;
            t1_last_reg    <= 1'b0;
            found_reg      <= 1'b0;
            slot_reg       <= '0;
            free_found_reg <= 1'b0;
            free_slot_reg  <= '0;
            tdone_reg      <= 1'b0;
            valid_reg      <= '0;
            pend_reg       <= '0;
            out_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    rdi_pkg::CFG_RULE_MODE:    mode_reg  <= cfg_data[1:0];
                    rdi_pkg::CFG_DWELL_TIME:   dwell_reg <= cfg_data;
                    rdi_pkg::CFG_VERTEX_COUNT: vcnt_reg  <= cfg_data[4:0];
                    default:                   ;
                endcase
            end

            if (out_valid_reg && res_ready && (state_reg != ST_HOLD))
            begin
                out_valid_reg <= 1'b0;
            end

            s1_valid_reg <= (state_reg == ST_RUN) && pact_reg;
            s1_first_reg <= (pcnt_reg == '0);
            s1_last_reg  <= (pcnt_reg == n_reg);
            s2_valid_reg <= s1_valid_reg && !s1_first_reg;
            s2_last_reg  <= s1_last_reg;
            if (s1_valid_reg)
            begin
                lx_reg    <= vx_q;
                ly_reg    <= vy_q;
                p1_reg    <= p1_next;
                p2_reg    <= p2_next;
                p3_reg    <= p3_next;
                p4_reg    <= p4_next;
                bbox_reg  <= bbox_next;
                cross_reg <= (vy_q > py_reg) != (ly_reg > py_reg);
                dypos_reg <= ly_reg > vy_q;
                dyneg_reg <= ly_reg < vy_q;
            end
            if (s2_valid_reg)
            begin
                if ((p1_reg == p2_reg) && bbox_reg)
                begin
                    bnd_reg <= 1'b1;
                end
                if (cross_reg && ((dypos_reg && (p3_reg > p4_reg))
                    || (dyneg_reg && (p3_reg < p4_reg))))
                begin
                    par_reg <= !par_reg;
                end
                if (s2_last_reg)
                begin
                    pdone_reg <= 1'b1;
                end
            end

            t1_valid_reg <= (state_reg == ST_RUN) && (tcnt_reg < TCW'(MAX_TRACKS));
            t1_idx_reg   <= tcnt_reg[TW-1:0];
            t1_last_reg  <= (tcnt_reg == TCW'(MAX_TRACKS - 1));
            if (t1_valid_reg)
            begin
                if (!found_reg)
                begin
                    if (valid_reg[t1_idx_reg] && (tag_q == cur_reg.track_id))
                    begin
                        found_reg <= 1'b1;
                        slot_reg  <= t1_idx_reg;
                    end
                    else if (!valid_reg[t1_idx_reg] && !free_found_reg)
                    begin
                        free_found_reg <= 1'b1;
                        free_slot_reg  <= t1_idx_reg;
                    end
                end
                if (t1_last_reg)
                begin
                    tdone_reg <= 1'b1;
                end
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        cur_reg  <= q_item;
                        pend_reg <= '0;
                        if (q_item.op == rdi_pkg::OP_CLEAR)
                        begin
                            valid_reg <= '0;
                        end
                        if (q_item.op == rdi_pkg::OP_OBS)
                        begin
                            state_reg      <= ST_RUN;
                            px_reg         <= to_coord(q_item.coord_x);
                            py_reg         <= to_coord(q_item.coord_y);
                            n_reg          <= n_next;
                            pcnt_reg       <= '0;
                            pact_reg       <= (32'(n_next) >= rdi_pkg::MIN_POLY_VERTICES);
                            pdone_reg      <= (32'(n_next) < rdi_pkg::MIN_POLY_VERTICES);
                            par_reg        <= 1'b0;
                            bnd_reg        <= 1'b0;
                            tcnt_reg       <= '0;
                            found_reg      <= 1'b0;
                            free_found_reg <= 1'b0;
                            tdone_reg      <= 1'b0;
                        end
                        else
                        begin
                            state_reg <= ST_HOLD;
                        end
                    end
                end
                ST_RUN:
                begin
                    if (pact_reg)
                    begin
                        pcnt_reg <= pcnt_reg + 1'b1;
                        if (pcnt_reg == n_reg)
                        begin
                            pact_reg <= 1'b0;
                        end
                    end
                    if (tcnt_reg < TCW'(MAX_TRACKS))
                    begin
                        tcnt_reg <= tcnt_reg + 1'b1;
                    end
                    if (run_done)
                    begin
                        pend_reg.event_kind       <= rdi_pkg::KIND_NONE;
                        pend_reg.event_track      <= cur_reg.track_id;
                        pend_reg.event_time       <= cur_reg.timestamp_ns;
                        pend_reg.event_class      <= cur_reg.object_class;
                        pend_reg.event_box_left   <= cur_reg.box_left;
                        pend_reg.event_box_top    <= cur_reg.box_top;
                        pend_reg.event_box_width  <= cur_reg.box_width;
                        pend_reg.event_box_height <= cur_reg.box_height;
                        pend_reg.inside_now       <= inside_w;
                        pend_reg.table_full       <= !found_reg && !free_found_reg;
                        if (found_reg)
                        begin
                            state_reg <= ST_FETCH;
                        end
                        else
                        begin
                            if (free_found_reg)
                            begin
                                valid_reg[free_slot_reg] <= 1'b1;
                            end
                            state_reg <= ST_HOLD;
                        end
                    end
                end
                ST_FETCH:
                begin
                    state_reg <= ST_EVAL;
                end
                ST_EVAL:
                begin
                    pend_reg.event_kind <= ev_kind;
                    state_reg           <= ST_HOLD;
                end
                ST_HOLD:
                begin
                    if (out_free)
                    begin
                        out_reg       <= pend_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> hdl/region_dwell_intrusion_rule_top.sv
// Top level of the region dwell / intrusion rule: input stage, queue, rule engine.
// Depends on rdi_pkg, rdi_channels, rdi_front, rdi_queue and rdi_back.
//
//   Channel   Direction   Carries
//   item      in          vertex loads, observations, table clears (valid/ready)
//   result    out         one event word per input word (valid/ready)
//   cfg       in          register writes: rule_mode, dwell_time_ns, vertex_count
//
// An observation sweeps the track table one tag per cycle while the edge pipeline
// tests one polygon edge per cycle beside it. A known track then passes through the
// fetch and evaluate states; a new track, a full table, a load, a clear or a no-op
// word goes straight to the hold state. Reset clears all valid bits at once; there is
// no clearing pass. Input words queue while an event word waits.
module region_dwell_intrusion_rule_top #(
    parameter int MAX_TRACKS   = rdi_pkg::MAX_TRACKS_DEF,
    parameter int MAX_VERTICES = rdi_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = rdi_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [rdi_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                   cfg_data,
    rdi_item_if.sink                      item,
    rdi_result_if.source                  result
);

    logic           push_valid;
    logic           push_ready;
    rdi_pkg::item_t push_item;
    logic           pop_valid;
    logic           pop_ready;
    rdi_pkg::item_t pop_item;
    rdi_pkg::res_t  res;

    rdi_front #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_item (push_item)
    );

    rdi_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_item (push_item),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item)
    );

    rdi_back #(
        .MAX_TRACKS  (MAX_TRACKS),
        .MAX_VERTICES(MAX_VERTICES),
        .COORD_BITS  (COORD_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .q_valid  (pop_valid),
        .q_ready  (pop_ready),
        .q_item   (pop_item),
        .res_valid(result.valid),
        .res_ready(result.ready),
        .res      (res)
    );

    assign result.event_kind       = res.event_kind;
    assign result.event_track      = res.event_track;
    assign result.event_time       = res.event_time;
    assign result.event_class      = res.event_class;
    assign result.event_box_left   = res.event_box_left;
    assign result.event_box_top    = res.event_box_top;
    assign result.event_box_width  = res.event_box_width;
    assign result.event_box_height = res.event_box_height;
    assign result.inside_now       = res.inside_now;
    assign result.table_full       = res.table_full;

endmodule

>>> sim/testbench.sv
// Testbench for region_dwell_intrusion_rule_top: vertex loads, observations and clears
// are checked against an in-bench predictor. Depends on rdi_pkg and rdi_channels.
`timescale 1ns / 1ps

module testbench;

    typedef struct {
        logic [1:0]  action;
        logic [3:0]  vertex_index;
        logic [15:0] coord_x;
        logic [15:0] coord_y;
        logic [31:0] track_id;
        logic [63:0] timestamp_ns;
        logic [7:0]  object_class;
        logic [15:0] box_left;
        logic [15:0] box_top;
        logic [15:0] box_width;
        logic [15:0] box_height;
    } obs_word_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] track;
        logic [63:0] tstamp;
        logic [7:0]  cls;
        logic [15:0] bl;
        logic [15:0] bt;
        logic [15:0] bw;
        logic [15:0] bh;
        logic        in_poly;
        logic        full;
    } event_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [rdi_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [63:0] cfg_data = '0;

    rdi_item_if item ();
    rdi_result_if result ();

    region_dwell_intrusion_rule_top dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .item(item), .result(result)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    obs_word_t pending_words[$];
    event_word_t expected_events[$];
    int errors = 0;
    longint cycles = 0;

    // Predictor state.
    logic [1:0]  p_mode;
    logic [63:0] p_dwell;
    logic [4:0]  p_count;
    logic signed [15:0] px_mem[16];
    logic signed [15:0] py_mem[16];
    logic        t_valid[64];
    logic [31:0] t_tag[64];
    logic        t_inside[64];
    logic        t_trig[64];
    logic [63:0] t_entered[64];

    function automatic bit point_in_region(logic signed [15:0] qx, logic signed [15:0] qy);
        int n;
        bit ins;
        int prev;
        longint cx, cy, lx, ly, x, y, dy, a, b;
        n = (p_count > 16) ? 16 : p_count;
        ins = 0;
        if (n < rdi_pkg::MIN_POLY_VERTICES)
            return 0;
        x = qx;
        y = qy;
        prev = n - 1;
        for (int i = 0; i < n; i++)
        begin
            cx = px_mem[i]; cy = py_mem[i]; lx = px_mem[prev]; ly = py_mem[prev];
            if ((cx - lx) * (y - ly) == (cy - ly) * (x - lx) &&
                x >= ((lx < cx) ? lx : cx) && x <= ((lx > cx) ? lx : cx) &&
                y >= ((ly < cy) ? ly : cy) && y <= ((ly > cy) ? ly : cy))
                return 1;
            if ((cy > y) != (ly > y))
            begin
                dy = ly - cy;
                a = (lx - cx) * (y - cy);
                b = (x - cx) * dy;
                if ((dy > 0 && a > b) || (dy < 0 && a < b))
                    ins = !ins;
            end
            prev = i;
        end
        return ins;
    endfunction

    function automatic event_word_t predict_event(obs_word_t w);
        event_word_t e;
        bit ins;
        int slot, free_slot;
        e = '0;
        if (w.action == rdi_pkg::ACT_LOAD)
        begin
            px_mem[w.vertex_index] = w.coord_x;
            py_mem[w.vertex_index] = w.coord_y;
            return e;
        end
        if (w.action == rdi_pkg::ACT_CLEAR)
        begin
            foreach (t_valid[k]) t_valid[k] = 1'b0;
            return e;
        end
        if (w.action != rdi_pkg::ACT_OBS)
            return e;
        ins = point_in_region(w.coord_x, w.coord_y);
        e.track = w.track_id; e.tstamp = w.timestamp_ns; e.cls = w.object_class;
        e.bl = w.box_left; e.bt = w.box_top; e.bw = w.box_width; e.bh = w.box_height;
        e.in_poly = ins;
        slot = -1;
        free_slot = -1;
        for (int k = 0; k < 64; k++)
        begin
            if (t_valid[k])
            begin
                if (t_tag[k] == w.track_id)
                begin
                    slot = k;
                    break;
                end
            end
            else if (free_slot < 0)
                free_slot = k;
        end
        if (slot < 0)
        begin
            if (free_slot < 0)
            begin
                e.full = 1'b1;
                return e;
            end
            t_valid[free_slot] = 1'b1;
            t_tag[free_slot] = w.track_id;
            t_inside[free_slot] = ins;
            t_trig[free_slot] = 1'b0;
            t_entered[free_slot] = ins ? w.timestamp_ns : 64'd0;
            return e;
        end
        if (!t_inside[slot] && ins)
        begin
            t_entered[slot] = w.timestamp_ns;
            t_trig[slot] = 1'b0;
            if (p_mode == rdi_pkg::MODE_ENTER)
                e.kind = rdi_pkg::KIND_ENTERED;
        end
        else if (t_inside[slot] && !ins)
        begin
            if (p_mode == rdi_pkg::MODE_LEAVE)
                e.kind = rdi_pkg::KIND_LEFT;
            t_entered[slot] = '0;
            t_trig[slot] = 1'b0;
        end
        if (ins && p_mode == rdi_pkg::MODE_INTRUDE && !t_trig[slot] && t_entered[slot] != 0 &&
            w.timestamp_ns >= t_entered[slot] &&
            w.timestamp_ns - t_entered[slot] >= p_dwell)
        begin
            e.kind = rdi_pkg::KIND_INTRUDED;
            t_trig[slot] = 1'b1;
        end
        t_inside[slot] = ins;
        return e;
    endfunction

    task automatic queue_word(obs_word_t w);
        pending_words.insert(pending_words.size(), w);
    endtask

    // Handshakes seen at the last rising edge.
    logic in_fire = 1'b0;
    logic out_fire = 1'b0;
    always @(posedge clk)
    begin
        in_fire <= item.valid && item.ready;
        out_fire <= result.valid && result.ready;
    end

    // Driver.
    int send_gap = 0;
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            item.valid <= 1'b0;
            item.action <= '0; item.vertex_index <= '0; item.coord_x <= '0;
            item.coord_y <= '0; item.track_id <= '0; item.timestamp_ns <= '0;
            item.object_class <= '0; item.box_left <= '0; item.box_top <= '0;
            item.box_width <= '0; item.box_height <= '0;
        end
        else if (!item.valid || in_fire)
        begin
            if (in_fire)
                send_gap = $urandom_range(0, 9);
            if (send_gap > 0)
            begin
                send_gap--;
                item.valid <= 1'b0;
            end
            else if (pending_words.size() > 0)
            begin
                obs_word_t w;
                w = pending_words.pop_front();
                expected_events.insert(expected_events.size(), predict_event(w));
                item.valid <= 1'b1;
                item.action <= w.action;
                item.vertex_index <= w.vertex_index;
                item.coord_x <= w.coord_x;
                item.coord_y <= w.coord_y;
                item.track_id <= w.track_id;
                item.timestamp_ns <= w.timestamp_ns;
                item.object_class <= w.object_class;
                item.box_left <= w.box_left;
                item.box_top <= w.box_top;
                item.box_width <= w.box_width;
                item.box_height <= w.box_height;
            end
            else
                item.valid <= 1'b0;
        end
    end

    // Receiver stall and monitor.
    int recv_gap = 0;
    always @(negedge clk)
    begin
        if (!rst_n)
            result.ready <= 1'b0;
        else
        begin
            if (out_fire)
                recv_gap = $urandom_range(0, 9);
            if (recv_gap > 0)
            begin
                recv_gap--;
                result.ready <= 1'b0;
            end
            else
                result.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && result.valid && result.ready)
        begin
            if (expected_events.size() == 0)
            begin
                $display("%0t: unexpected event word kind %0d", $realtime, result.event_kind);
                errors++;
            end
            else
            begin
                event_word_t e;
                event_word_t a;
                e = expected_events.pop_front();
                a.kind = result.event_kind; a.track = result.event_track;
                a.tstamp = result.event_time; a.cls = result.event_class;
                a.bl = result.event_box_left; a.bt = result.event_box_top;
                a.bw = result.event_box_width; a.bh = result.event_box_height;
                a.in_poly = result.inside_now; a.full = result.table_full;
                if (a != e)
                begin
                    $display("%0t: mismatch expected %p actual %p", $realtime, e, a);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(logic [rdi_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == rdi_pkg::CFG_RULE_MODE)
            p_mode = val[1:0];
        else if (idx == rdi_pkg::CFG_DWELL_TIME)
            p_dwell = val;
        else
            p_count = val[4:0];
    endtask

    task automatic drain();
        while (pending_words.size() > 0 || expected_events.size() > 0 || item.valid)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    function automatic obs_word_t random_word(logic [1:0] act);
        obs_word_t w;
        w.action = act;
        w.vertex_index = 4'($urandom);
        w.coord_x = 16'($urandom);
        w.coord_y = 16'($urandom);
        w.track_id = $urandom;
        w.timestamp_ns = {$urandom, $urandom};
        w.object_class = 8'($urandom);
        w.box_left = 16'($urandom);
        w.box_top = 16'($urandom);
        w.box_width = 16'($urandom);
        w.box_height = 16'($urandom);
        return w;
    endfunction

    task automatic add_vertex(int idx, int x, int y);
        obs_word_t w;
        w = random_word(rdi_pkg::ACT_LOAD);
        w.vertex_index = 4'(idx);
        w.coord_x = 16'(x);
        w.coord_y = 16'(y);
        queue_word(w);
    endtask

    task automatic add_obs(logic [31:0] id, logic [63:0] ts, int x, int y);
        obs_word_t w;
        w = random_word(rdi_pkg::ACT_OBS);
        w.track_id = id;
        w.timestamp_ns = ts;
        w.coord_x = 16'(x);
        w.coord_y = 16'(y);
        queue_word(w);
    endtask

    logic [63:0] clock_ns;
    int nv;

    task automatic load_polygon(int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(200, 32000);
            add_vertex(i, $rtoi(r * $cos(6.2831853 * i / n)),
                       $rtoi(r * $sin(6.2831853 * i / n)));
        end
    endtask

    initial
    begin
        obs_word_t w;
        p_mode = '0; p_dwell = '0; p_count = '0;
        foreach (t_valid[k]) t_valid[k] = 1'b0;
        foreach (px_mem[k]) begin px_mem[k] = '0; py_mem[k] = '0; end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: square with extreme corners, boundary points, too few vertices.
        for (int i = 0; i < 16; i++) add_vertex(i, 0, 0);
        add_vertex(0, -32768, -32768);
        add_vertex(1, 32767, -32768);
        add_vertex(2, 32767, 32767);
        add_vertex(3, -32768, 32767);
        drain();
        write_reg(rdi_pkg::CFG_VERTEX_COUNT, 2);
        write_reg(rdi_pkg::CFG_RULE_MODE, rdi_pkg::MODE_ENTER);
        add_obs(1, 0, 0, 0);
        drain();
        write_reg(rdi_pkg::CFG_VERTEX_COUNT, 4);
        add_obs(1, 5, 0, 0);
        add_obs(2, 6, 32767, 0);
        add_obs(3, 7, -32768, -32768);
        w = random_word(rdi_pkg::OP_NOP); queue_word(w);
        drain();
        write_reg(rdi_pkg::CFG_RULE_MODE, rdi_pkg::MODE_LEAVE);
        write_reg(rdi_pkg::CFG_VERTEX_COUNT, 3);
        add_obs(2, 8, 32767, 32767);
        add_obs(2, 9, -32768, 32767);
        drain();
        write_reg(rdi_pkg::CFG_VERTEX_COUNT, 31);
        write_reg(rdi_pkg::CFG_RULE_MODE, rdi_pkg::MODE_INTRUDE);
        write_reg(rdi_pkg::CFG_DWELL_TIME, 0);
        add_obs(7, 0, 0, 0);
        add_obs(7, 100, 0, 0);
        add_obs(8, 100, 0, 0);
        add_obs(8, 50, 0, 0);
        drain();
        write_reg(rdi_pkg::CFG_DWELL_TIME, 64'hffff_ffff_ffff_ffff);
        add_obs(9, 1, 0, 0);
        add_obs(9, 64'hffff_ffff_ffff_ffff, 0, 0);
        w = random_word(rdi_pkg::ACT_CLEAR); queue_word(w);
        // Fill the table past capacity.
        for (int i = 0; i < 66; i++) add_obs(1000 + i, 1, 0, 0);
        w = random_word(rdi_pkg::ACT_CLEAR); queue_word(w);
        drain();
        write_reg(rdi_pkg::CFG_RULE_MODE, rdi_pkg::MODE_SILENT);

        // Random phases: a fresh polygon and setting, then tracks moving in and out.
        clock_ns = 1000;
        for (int ph = 0; ph < 12; ph++)
        begin
            drain();
            nv = (ph % 4 == 0) ? 16 : $urandom_range(3, 8);
            load_polygon(nv);
            drain();
            write_reg(rdi_pkg::CFG_VERTEX_COUNT, (ph == 5) ? $urandom_range(0, 2) :
                      ((ph == 7) ? $urandom_range(17, 31) : nv));
            write_reg(rdi_pkg::CFG_RULE_MODE, $urandom_range(0, 3));
            write_reg(rdi_pkg::CFG_DWELL_TIME, (ph == 3) ? 0 : $urandom_range(0, 3000));
            for (int i = 0; i < 140; i++)
            begin
                int sel;
                sel = $urandom_range(0, 99);
                clock_ns = clock_ns + $urandom_range(0, 400);
                if (sel < 85)
                    add_obs($urandom_range(0, 11), (sel < 3) ? 0 : clock_ns,
                            $urandom_range(0, 1) ? $signed($urandom_range(0, 400)) - 200
                                                 : $signed($urandom % 65536) - 32768,
                            $urandom_range(0, 1) ? $signed($urandom_range(0, 400)) - 200
                                                 : $signed($urandom % 65536) - 32768);
                else if (sel < 95)
                    queue_word(random_word(rdi_pkg::ACT_OBS));
                else if (sel < 97)
                    queue_word(random_word(rdi_pkg::ACT_CLEAR));
                else
                    queue_word(random_word(rdi_pkg::OP_NOP));
            end
        end
        drain();
        if (errors == 0 && expected_events.size() == 0)
            $display("region_dwell_intrusion_rule_top verification clean");
        else
            $display("region_dwell_intrusion_rule_top verification failed");
        $finish;
    end

    initial
    begin
        wait (cycles > 600000);
        $display("region_dwell_intrusion_rule_top verification failed");
        $finish;
    end
endmodule

>>> sim.f
hdl/rdi_pkg.sv
hdl/rdi_channels.sv
hdl/rdi_front.sv
hdl/rdi_queue.sv
hdl/rdi_back.sv
hdl/region_dwell_intrusion_rule_top.sv
sim/testbench.sv
